// File: rtl/stb_pkg.sv
// shared types and constants for the timer slot bank
package stb_pkg;

    localparam int NUM_SLOTS_DEF    = 32;
    localparam int PERIOD_WIDTH_DEF = 32;

    // fixed field widths of the request and result channels
    localparam int OP_W        = 2;
    localparam int SLOT_ID_W   = 5;
    localparam int PERIOD_IN_W = 32;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CNT_W       = 6;

    localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'b01;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 2'b10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_REGISTER   = 2'd1,
        OP_UNREGISTER = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_NO_FREE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_REG_ARM,
        S_RESP
    } state_t;

    // commands from the controller to the free slot list
    typedef struct packed {
        logic push;
        logic pop;
        logic rd_en;
    } fl_cmd_t;

    typedef struct packed {
        logic empty;
    } fl_stat_t;

endpackage

// File: rtl/stb_if.sv
// request and result channel interfaces of the timer slot bank
interface stb_cmd_if
    import stb_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        op;
    logic [SLOT_ID_W-1:0]   slot_id;
    logic [PERIOD_IN_W-1:0] period;
    logic [MODE_W-1:0]      mode;

    modport source (output valid, op, slot_id, period, mode, input ready);
    modport sink   (input valid, op, slot_id, period, mode, output ready);
endinterface

interface stb_rsp_if
    import stb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_ID_W-1:0] slot_out;
    logic                 fired;
    logic                 freed;
    logic [CNT_W-1:0]     expired_count;
    logic                 last;

    modport source (output valid, status, slot_out, fired, freed, expired_count, last,
                    input ready);
    modport sink   (input valid, status, slot_out, fired, freed, expired_count, last,
                    output ready);
endinterface

// File: rtl/stb_ram.sv
// generic simple dual port ram with registered read
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/stb_free_list.sv
// fifo of free slot numbers, kept in a ram with a fill count for the reset order
module stb_free_list
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fl_cmd_t                      cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0] push_slot,
    output logic [$clog2(NUM_SLOTS)-1:0] head_slot,
    output fl_stat_t                     stat
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_PTR = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [IDX_W-1:0]  FULL_CNT = IDX_W'(NUM_SLOTS);

    logic [SLOT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [SLOT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] ram_rdata;

    stb_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (push_slot),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rdata)
    );

    // positions past the fill count have not been written yet and read as their own index
    assign head_slot  = (IDX_W'(rd_ptr_reg) < fill_reg) ? ram_rdata : rd_ptr_reg;
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        if (cmd.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (fill_reg != FULL_CNT)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({cmd.push, cmd.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= FULL_CNT;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            fill_reg   <= fill_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cmd.push |-> count_reg != FULL_CNT)
        else $error("free list overflow");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |-> count_reg != '0)
        else $error("free list underflow");

endmodule

// File: rtl/software_timer_slot_bank.sv
// timer slot bank top level: request decode, tick walk and result register
//
// requests come in on cmd: op tick, register or unregister, with slot_id,
// period and mode. results go out on rsp; each result carries last, which
// marks the final result of its request.
// register and unregister give one result, written to the output register
// from the S_REG_ARM or S_RESP state that follows the request once rsp is free.
// a tick reads every slot once through the slot ram read ports, one slot per
// cycle while no fired result waits on rsp, then drains its last read and gives
// the summary. a fired slot gives one result before the summary.
// one request is worked on at a time; cmd.ready is high only when idle, and
// a request can be taken while the last result of the previous one still
// sits in the output register.
// when a fired slot meets a stalled rsp, the tick walk halts with the slot
// ram read held and resumes without losing a slot.
// reset empties the output register, frees all slots (free order 0 upward)
// and needs no clearing pass; the slot rams are written when a slot is armed.
module software_timer_slot_bank
    import stb_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    stb_cmd_if.sink   cmd,
    stb_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
    localparam int CFG_W  = PERIOD_WIDTH + 1;
    localparam logic [IDX_W-1:0] SLOT_CNT = IDX_W'(NUM_SLOTS);

    state_t state_reg, state_next;

    logic [NUM_SLOTS-1:0]    allocated_reg, allocated_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    p_valid_reg, p_valid_next;
    logic [SLOT_W-1:0]       p_idx_reg, p_idx_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [PERIOD_WIDTH-1:0] arm_period_reg, arm_period_next;
    logic                    arm_one_shot_reg, arm_one_shot_next;
    status_t                 resp_status_reg, resp_status_next;
    logic [SLOT_ID_W-1:0]    resp_slot_reg, resp_slot_next;
    logic                    resp_release_reg, resp_release_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]     rsp_status_reg, rsp_status_next;
    logic [SLOT_ID_W-1:0]    rsp_slot_reg, rsp_slot_next;
    logic                    rsp_fired_reg, rsp_fired_next;
    logic                    rsp_freed_reg, rsp_freed_next;
    logic [CNT_W-1:0]        rsp_cnt_reg, rsp_cnt_next;
    logic                    rsp_last_reg, rsp_last_next;

    logic                    accept;
    logic                    out_free;
    logic [PERIOD_WIDTH-1:0] period_eff;
    logic                    reg_ok;
    logic                    tick_done;

    logic                    slot_rd_en;
    logic                    rem_we;
    logic                    cfg_we;
    logic [SLOT_W-1:0]       slot_wr_addr;
    logic [PERIOD_WIDTH-1:0] rem_wdata;
    logic [PERIOD_WIDTH-1:0] rem_rdata;
    logic [CFG_W-1:0]        cfg_rdata;

    logic                    p_alloc;
    logic [PERIOD_WIDTH-1:0] p_dec;
    logic                    p_fire;
    logic                    p_stall;

    fl_cmd_t                 fl_cmd;
    fl_stat_t                fl_stat;
    logic [SLOT_W-1:0]       fl_push_slot;
    logic [SLOT_W-1:0]       fl_head;

    stb_ram #(
        .WIDTH (PERIOD_WIDTH),
        .DEPTH (NUM_SLOTS)
    ) u_rem_ram (
        .clk     (clk),
        .wr_en   (rem_we),
        .wr_addr (slot_wr_addr),
        .wr_data (rem_wdata),
        .rd_en   (slot_rd_en),
        .rd_addr (rd_idx_reg[SLOT_W-1:0]),
        .rd_data (rem_rdata)
    );

    // one-shot flag on top of the reload period
    stb_ram #(
        .WIDTH (CFG_W),
        .DEPTH (NUM_SLOTS)
    ) u_cfg_ram (
        .clk     (clk),
        .wr_en   (cfg_we),
        .wr_addr (slot_wr_addr),
        .wr_data ({arm_one_shot_reg, arm_period_reg}),
        .rd_en   (slot_rd_en),
        .rd_addr (rd_idx_reg[SLOT_W-1:0]),
        .rd_data (cfg_rdata)
    );

    stb_free_list #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_free_list (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fl_cmd),
        .push_slot (fl_push_slot),
        .head_slot (fl_head),
        .stat      (fl_stat)
    );

    assign cmd.ready  = (state_reg == S_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign period_eff = PERIOD_WIDTH'(cmd.period);
    assign reg_ok     = ((cmd.mode == MODE_ONE_SHOT) || (cmd.mode == MODE_PERIODIC))
                        && (period_eff != '0) && !fl_stat.empty;
    assign tick_done  = !p_valid_reg && (rd_idx_reg == SLOT_CNT);

    // tick walk, second stage: slot data is back from the rams
    assign p_alloc = allocated_reg[p_idx_reg];
    assign p_dec   = rem_rdata - 1'b1;
    assign p_fire  = p_valid_reg && p_alloc && (p_dec == '0);
    assign p_stall = p_fire && !out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == OP_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else if ((cmd.op == OP_REGISTER) && reg_ok)
                    begin
                        state_next = S_REG_ARM;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_TICK:
            begin
                if (tick_done && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_REG_ARM, S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        allocated_next    = allocated_reg;
        rd_idx_next       = rd_idx_reg;
        p_valid_next      = p_valid_reg;
        p_idx_next        = p_idx_reg;
        cnt_next          = cnt_reg;
        arm_period_next   = arm_period_reg;
        arm_one_shot_next = arm_one_shot_reg;
        resp_status_next  = resp_status_reg;
        resp_slot_next    = resp_slot_reg;
        resp_release_next = resp_release_reg;

        slot_rd_en   = 1'b0;
        rem_we       = 1'b0;
        cfg_we       = 1'b0;
        slot_wr_addr = p_idx_reg;
        rem_wdata    = p_dec;
        fl_cmd       = '0;
        fl_push_slot = p_idx_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_fired_next  = rsp_fired_reg;
        rsp_freed_next  = rsp_freed_reg;
        rsp_cnt_next    = rsp_cnt_reg;
        rsp_last_next   = rsp_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    resp_status_next  = STATUS_INVALID;
                    resp_slot_next    = '0;
                    resp_release_next = 1'b0;
                    case (cmd.op)
                        OP_TICK:
                        begin
                            rd_idx_next  = '0;
                            p_valid_next = 1'b0;
                            cnt_next     = '0;
                        end
                        OP_REGISTER:
                        begin
                            arm_period_next   = period_eff;
                            arm_one_shot_next = (cmd.mode == MODE_ONE_SHOT);
                            if (reg_ok)
                            begin
                                fl_cmd.rd_en = 1'b1;
                            end
                            else if (((cmd.mode == MODE_ONE_SHOT) ||
                                      (cmd.mode == MODE_PERIODIC)) && (period_eff != '0))
                            begin
                                resp_status_next = STATUS_NO_FREE;
                            end
                        end
                        OP_UNREGISTER:
                        begin
                            resp_slot_next = cmd.slot_id;
                            if ((32'(cmd.slot_id) < 32'(NUM_SLOTS)) &&
                                allocated_reg[SLOT_W'(cmd.slot_id)])
                            begin
                                resp_status_next  = STATUS_OK;
                                resp_release_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            resp_status_next = STATUS_INVALID;
                        end
                    endcase
                end
            end
            S_TICK:
            begin
                if (!p_stall)
                begin
                    if (p_valid_reg && p_alloc)
                    begin
                        rem_we       = 1'b1;
                        slot_wr_addr = p_idx_reg;
                        rem_wdata    = (p_fire && !cfg_rdata[PERIOD_WIDTH]) ?
                                       cfg_rdata[PERIOD_WIDTH-1:0] : p_dec;
                    end
                    if (p_fire)
                    begin
                        rsp_valid_next  = 1'b1;
                        rsp_status_next = STATUS_OK;
                        rsp_slot_next   = SLOT_ID_W'(p_idx_reg);
                        rsp_fired_next  = 1'b1;
                        rsp_freed_next  = cfg_rdata[PERIOD_WIDTH];
                        rsp_cnt_next    = '0;
                        rsp_last_next   = 1'b0;
                        if (cfg_rdata[PERIOD_WIDTH])
                        begin
                            allocated_next[p_idx_reg] = 1'b0;
                            fl_cmd.push               = 1'b1;
                            fl_push_slot              = p_idx_reg;
                            cnt_next                  = cnt_reg + 1'b1;
                        end
                    end
                    // first stage: read the next slot
                    if (rd_idx_reg != SLOT_CNT)
                    begin
                        slot_rd_en   = 1'b1;
                        p_valid_next = 1'b1;
                        p_idx_next   = rd_idx_reg[SLOT_W-1:0];
                        rd_idx_next  = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        p_valid_next = 1'b0;
                    end
                end
                if (tick_done && out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STATUS_OK;
                    rsp_slot_next   = '0;
                    rsp_fired_next  = 1'b0;
                    rsp_freed_next  = 1'b0;
                    rsp_cnt_next    = CNT_W'(cnt_reg);
                    rsp_last_next   = 1'b1;
                end
            end
            S_REG_ARM:
            begin
                if (out_free)
                begin
                    fl_cmd.pop              = 1'b1;
                    rem_we                  = 1'b1;
                    cfg_we                  = 1'b1;
                    slot_wr_addr            = fl_head;
                    rem_wdata               = arm_period_reg;
                    allocated_next[fl_head] = 1'b1;
                    rsp_valid_next          = 1'b1;
                    rsp_status_next         = STATUS_OK;
                    rsp_slot_next           = SLOT_ID_W'(fl_head);
                    rsp_fired_next          = 1'b0;
                    rsp_freed_next          = 1'b0;
                    rsp_cnt_next            = '0;
                    rsp_last_next           = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    if (resp_release_reg)
                    begin
                        allocated_next[SLOT_W'(resp_slot_reg)] = 1'b0;
                        fl_cmd.push                            = 1'b1;
                        fl_push_slot                           = SLOT_W'(resp_slot_reg);
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = resp_status_reg;
                    rsp_slot_next   = resp_slot_reg;
                    rsp_fired_next  = 1'b0;
                    rsp_freed_next  = 1'b0;
                    rsp_cnt_next    = '0;
                    rsp_last_next   = 1'b1;
                end
            end
            default:
            begin
                p_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            allocated_reg <= '0;
            rd_idx_reg    <= '0;
            p_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            allocated_reg <= allocated_next;
            rd_idx_reg    <= rd_idx_next;
            p_valid_reg   <= p_valid_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg        <= p_idx_next;
        arm_period_reg   <= arm_period_next;
        arm_one_shot_reg <= arm_one_shot_next;
        resp_status_reg  <= resp_status_next;
        resp_slot_reg    <= resp_slot_next;
        resp_release_reg <= resp_release_next;
        rsp_status_reg   <= rsp_status_next;
        rsp_slot_reg     <= rsp_slot_next;
        rsp_fired_reg    <= rsp_fired_next;
        rsp_freed_reg    <= rsp_freed_next;
        rsp_cnt_reg      <= rsp_cnt_next;
        rsp_last_reg     <= rsp_last_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.slot_out      = rsp_slot_reg;
    assign rsp.fired         = rsp_fired_reg;
    assign rsp.freed         = rsp_freed_reg;
    assign rsp.expired_count = rsp_cnt_reg;
    assign rsp.last          = rsp_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REG_ARM |-> !fl_stat.empty)
        else $error("arming a slot with an empty free list");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !p_valid_reg)
        else $error("tick walk still busy while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK && tick_done && out_free)
        |=> (state_reg == S_IDLE) && rsp.valid && rsp.last && !rsp.fired)
        else $error("tick did not close with a summary result");

endmodule
